@@ src/sb2d_pkg.sv @@
// shared constants and types for the signed binary to decimal ascii converter
package sb2d_pkg;

    localparam int VALUE_BITS = 64;
    localparam int IN_BITS    = 64;
    localparam int CHAR_BITS  = 8;
    localparam int BCD_BITS   = 4;
    // decimal digits of 2**(VALUE_BITS-1), the largest magnitude
    localparam int NUM_DIGITS = ((VALUE_BITS - 1) * 30103) / 100000 + 1;
    localparam int CNT_W      = $clog2(VALUE_BITS);
    localparam int DIG_W      = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;

    localparam logic [CHAR_BITS-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_BITS-1:0] CHAR_MINUS = 8'h2D;
    localparam logic [BCD_BITS-1:0]  BCD_ADJ_MIN = 4'd5;
    localparam logic [BCD_BITS-1:0]  BCD_ADJ     = 4'd3;

    typedef struct packed {
        logic clear;
        logic shift_bit;
        logic shift_digit;
    } t_cell_ctl;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_CONV = 5'b00010,
        S_SKIP = 5'b00100,
        S_SIGN = 5'b01000,
        S_EMIT = 5'b10000
    } t_state;

endpackage

@@ src/sb2d_cell.sv @@
// one bcd digit cell: clear, shift-add-3 step or whole-digit shift toward the top
module sb2d_cell (
    input  logic                       i_clk,
    input  sb2d_pkg::t_cell_ctl        i_ctl,
    input  logic                       i_bit,
    input  logic [sb2d_pkg::BCD_BITS-1:0] i_digit,
    output logic                       o_bit,
    output logic [sb2d_pkg::BCD_BITS-1:0] o_digit
);
    import sb2d_pkg::*;

    logic [BCD_BITS-1:0] r_d;
    logic [BCD_BITS-1:0] n_d;
    logic [BCD_BITS-1:0] adj;

    always_comb begin
        adj = (r_d >= BCD_ADJ_MIN) ? r_d + BCD_ADJ : r_d;
        n_d = r_d;
        if (i_ctl.clear) begin
            n_d = '0;
        end else if (i_ctl.shift_bit) begin
            n_d = {adj[BCD_BITS-2:0], i_bit};
        end else if (i_ctl.shift_digit) begin
            n_d = i_digit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_d <= n_d;
    end

    assign o_bit   = adj[BCD_BITS-1];
    assign o_digit = r_d;

endmodule

@@ src/sb2d_chain.sv @@
// row of bcd digit cells, lowest digit fed by the binary bit stream
module sb2d_chain (
    input  logic                          i_clk,
    input  sb2d_pkg::t_cell_ctl           i_ctl,
    input  logic                          i_bit,
    output logic [sb2d_pkg::BCD_BITS-1:0] o_top
);
    import sb2d_pkg::*;

    logic [NUM_DIGITS:0]              bits;
    logic [BCD_BITS-1:0] digits [NUM_DIGITS+1];

    assign bits[0]   = i_bit;
    assign digits[0] = '0;

    for (genvar g = 0; g < NUM_DIGITS; g++) begin : g_cell
        sb2d_cell u_cell (
            .i_clk   (i_clk),
            .i_ctl   (i_ctl),
            .i_bit   (bits[g]),
            .i_digit (digits[g]),
            .o_bit   (bits[g+1]),
            .o_digit (digits[g+1])
        );
    end

    assign o_top = digits[NUM_DIGITS];

endmodule

@@ src/signed_binary_to_decimal_ascii.sv @@
// top level: signed binary integer in, decimal ascii characters out
//
// input channel: one item per signed integer on i_s_tdata, taken when
// i_s_tvalid and o_s_tready are both high. only the low VALUE_BITS bits count.
// output channel: one item per character on o_m_tdata, most significant first,
// a leading '-' for negative values, o_m_tlast high on the final character.
// the magnitude is shifted one bit per cycle through a row of bcd digit cells,
// then leading zeros are shifted out one cell per cycle (up to NUM_DIGITS-1 of
// them), then one character leaves per cycle while the receiver takes them.
// a new item is taken once the previous item's last character sits in the
// output register, so that register overlaps with the next conversion.
// a stalled receiver holds the output register and freezes character emission.
// synchronous active-low reset returns the control to idle and empties the
// output register; the digit cells need no reset.
module signed_binary_to_decimal_ascii (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    input  logic [sb2d_pkg::IN_BITS-1:0]       i_s_tdata,   // value
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    output logic [sb2d_pkg::CHAR_BITS-1:0]     o_m_tdata,   // char_code
    output logic                               o_m_tlast    // last_char
);
    import sb2d_pkg::*;

    t_state                 r_state, n_state;
    logic [VALUE_BITS-1:0]  r_mag, n_mag;
    logic                   r_neg, n_neg;
    logic [CNT_W-1:0]       r_cnt, n_cnt;
    logic [DIG_W-1:0]       r_dig, n_dig;
    logic                   r_out_valid, n_out_valid;
    logic [CHAR_BITS-1:0]   r_out_char, n_out_char;
    logic                   r_out_last, n_out_last;

    t_cell_ctl              ctl;
    logic [BCD_BITS-1:0]    top;
    logic [VALUE_BITS-1:0]  raw;
    logic                   out_free;
    logic                   in_acc;

    sb2d_chain u_chain (
        .i_clk (i_clk),
        .i_ctl (ctl),
        .i_bit (r_mag[VALUE_BITS-1]),
        .o_top (top)
    );

    assign raw      = i_s_tdata[VALUE_BITS-1:0];
    assign out_free = !r_out_valid || i_m_tready;
    assign in_acc   = i_s_tvalid && (r_state == S_IDLE);

    always_comb begin
        n_state     = r_state;
        n_mag       = r_mag;
        n_neg       = r_neg;
        n_cnt       = r_cnt;
        n_dig       = r_dig;
        n_out_valid = r_out_valid && !i_m_tready;
        n_out_char  = r_out_char;
        n_out_last  = r_out_last;
        ctl         = '0;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_neg   = raw[VALUE_BITS-1];
                    n_mag   = raw[VALUE_BITS-1] ? (~raw + 1'b1) : raw;
                    n_cnt   = CNT_W'(VALUE_BITS - 1);
                    ctl.clear = 1'b1;
                    n_state = S_CONV;
                end
            end
            S_CONV: begin
                ctl.shift_bit = 1'b1;
                n_mag = {r_mag[VALUE_BITS-2:0], 1'b0};
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    n_dig   = DIG_W'(NUM_DIGITS - 1);
                    n_state = S_SKIP;
                end
            end
            S_SKIP: begin
                if (top == '0 && r_dig != '0) begin
                    ctl.shift_digit = 1'b1;
                    n_dig = r_dig - 1'b1;
                end else begin
                    n_state = r_neg ? S_SIGN : S_EMIT;
                end
            end
            S_SIGN: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_char  = CHAR_MINUS;
                    n_out_last  = 1'b0;
                    n_state     = S_EMIT;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_char  = CHAR_ZERO + CHAR_BITS'(top);
                    n_out_last  = (r_dig == '0);
                    ctl.shift_digit = 1'b1;
                    if (r_dig == '0) begin
                        n_state = S_IDLE;
                    end else begin
                        n_dig = r_dig - 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
        r_mag      <= n_mag;
        r_neg      <= n_neg;
        r_cnt      <= n_cnt;
        r_dig      <= n_dig;
        r_out_char <= n_out_char;
        r_out_last <= n_out_last;
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_char;
    assign o_m_tlast  = r_out_last;

endmodule

@@ tb/tb_signed_binary_to_decimal_ascii.sv @@
// testbench for the signed binary to decimal ascii converter with a self-checking text predictor
`timescale 1ns / 100ps

module tb_signed_binary_to_decimal_ascii;

    import sb2d_pkg::*;

    localparam int LONG_HOLD_CYCLES = 400;
    localparam int DRAIN_CYCLES     = 120;

    typedef struct packed {
        logic [CHAR_BITS-1:0] code;
        logic                 last_char;
    } t_ascii_char;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_s_tvalid = 1'b0;
    logic                 o_s_tready;
    logic [IN_BITS-1:0]   i_s_tdata = '0;    // value
    logic                 o_m_tvalid;
    logic                 i_m_tready = 1'b0;
    logic [CHAR_BITS-1:0] o_m_tdata;         // char_code
    logic                 o_m_tlast;         // last_char

    logic [IN_BITS-1:0] pending_values[$];
    t_ascii_char        expected_chars[$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    logic hold_arm     = 1'b0;
    int hold_left      = 0;

    int mismatch_count = 0;
    int values_taken   = 0;
    int negatives_seen = 0;
    int chars_checked  = 0;
    int hold_count     = 0;

    signed_binary_to_decimal_ascii dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        mismatch_count++;
    endtask

    // decimal text of one integer, queued as expected characters
    function automatic void predict_text(input logic [IN_BITS-1:0] value);
        logic [63:0] mask;
        logic [63:0] raw;
        logic [63:0] mag;
        logic [63:0] rem;
        logic        negative;
        logic [3:0]  digit_buf[20];
        int          n;
        t_ascii_char c;
        mask = (VALUE_BITS >= 64) ? '1 : ((64'd1 << VALUE_BITS) - 64'd1);
        raw = value & mask;
        negative = raw[VALUE_BITS-1];
        mag = negative ? ((~raw + 64'd1) & mask) : raw;
        n = 0;
        do begin
            rem = mag % 64'd10;
            digit_buf[n] = rem[3:0];
            n++;
            mag = mag / 64'd10;
        end while (mag != 0 && n < 20);
        if (negative) begin
            c.code = CHAR_MINUS;
            c.last_char = 1'b0;
            expected_chars.push_back(c);
        end
        for (int i = n - 1; i >= 0; i--) begin
            c.code = CHAR_ZERO + {4'd0, digit_buf[i]};
            c.last_char = (i == 0);
            expected_chars.push_back(c);
        end
    endfunction

    // sender
    always @(posedge i_clk) begin
        logic                 next_valid;
        logic [IN_BITS-1:0]   next_data;
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else begin
            next_valid = i_s_tvalid;
            next_data = i_s_tdata;
            if (i_s_tvalid && o_s_tready) begin
                predict_text(i_s_tdata);
                values_taken++;
                if (i_s_tdata[VALUE_BITS-1])
                    negatives_seen++;
            end
            if (!i_s_tvalid || o_s_tready) begin
                if (pending_values.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    next_valid = 1'b1;
                    next_data = pending_values.pop_front();
                end else begin
                    next_valid = 1'b0;
                end
            end
            i_s_tvalid <= next_valid;
            i_s_tdata <= next_data;
        end
    end

    // long receiver hold, counted here
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
        end else if (hold_arm) begin
            hold_left <= LONG_HOLD_CYCLES;
            hold_count++;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // receiver and checker
    always @(posedge i_clk) begin
        t_ascii_char want;
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else begin
            if (o_m_tvalid && i_m_tready) begin
                if (expected_chars.size() == 0) begin
                    report_mismatch($sformatf("unexpected char 0x%02h last %0b",
                                              o_m_tdata, o_m_tlast));
                end else begin
                    want = expected_chars.pop_front();
                    chars_checked++;
                    if (o_m_tdata !== want.code)
                        report_mismatch($sformatf("char 0x%02h, want 0x%02h",
                                                  o_m_tdata, want.code));
                    if (o_m_tlast !== want.last_char)
                        report_mismatch($sformatf("tlast %0b, want %0b on char 0x%02h",
                                                  o_m_tlast, want.last_char, want.code));
                end
            end
            i_m_tready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic wait_drained();
        do @(posedge i_clk);
        while (pending_values.size() != 0 || i_s_tvalid || expected_chars.size() != 0);
    endtask

    task automatic run_phase(input int idle_pct, input int stall_pct, input int count,
                             input bit long_hold);
        logic [IN_BITS-1:0] v;
        @(posedge i_clk);
        send_idle_pct <= idle_pct;
        recv_stall_pct <= stall_pct;
        @(posedge i_clk);
        for (int k = 0; k < count; k++) begin
            v = {$urandom, $urandom};
            case ($urandom_range(3))
                0: ;
                1: v = v >> $urandom_range(63);
                2: v = ~(v >> $urandom_range(63)) + 64'd1;
                default: begin
                    v = 64'($urandom_range(999));
                    if ($urandom_range(1))
                        v = ~v + 64'd1;
                end
            endcase
            pending_values.push_back(v);
        end
        if (long_hold) begin
            hold_arm <= 1'b1;
            @(posedge i_clk);
            hold_arm <= 1'b0;
        end
        wait_drained();
    endtask

    initial begin
        logic [IN_BITS-1:0] corner_values[$];
        corner_values = '{
            64'd0, 64'd1, -64'sd1, 64'd9, 64'd10, -64'sd10, 64'd99, 64'd100,
            64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000, 64'h8000_0000_0000_0001,
            64'd123456789, -64'sd123456789, 64'd999999999999999999,
            64'd1000000000000000000, -64'sd1000000000000000000,
            64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA,
            64'd4294967295, -64'sd2147483648
        };
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (corner_values[k])
            pending_values.push_back(corner_values[k]);
        wait_drained();

        run_phase(0, 0, 50, 1'b0);
        run_phase(49, 0, 50, 1'b0);
        run_phase(0, 49, 50, 1'b0);
        run_phase(8, 8, 50, 1'b0);
        run_phase(0, 0, 15, 1'b1);

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (expected_chars.size() != 0)
            report_mismatch($sformatf("%0d chars never arrived", expected_chars.size()));

        $display("converted %0d integers (%0d negative, corner values included) into %0d chars",
                 values_taken, negatives_seen, chars_checked);
        $display("traffic: free flow, sender gaps, receiver stalls, both, %0d long hold(s)",
                 hold_count);
        if (mismatch_count == 0) begin
            $display("[signed_binary_to_decimal_ascii] OK");
        end else begin
            $display("[signed_binary_to_decimal_ascii] ERROR");
        end
        $finish;
    end

    initial begin
        #8_000_000;
        $display("timeout with %0d chars outstanding", expected_chars.size());
        $display("[signed_binary_to_decimal_ascii] ERROR");
        $finish;
    end

endmodule
